### src/tlpt_pkg.sv
// Shared types, codes and constants of the two-level page table mapper.
package tlpt_pkg;

   localparam int VPAGE_W = 28;
   localparam int PPAGE_W = 28;
   localparam int CNT_W = 16;

   localparam logic [1:0] CMD_MAP = 2'd0;
   localparam logic [1:0] CMD_UNMAP = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BEYOND = 2'd1;
   localparam logic [1:0] ST_UNMAPPED = 2'd2;

   // entry memory word layout
   localparam int MEM_W = 32;
   localparam int WB_READ = 28;
   localparam int WB_WRITE = 29;
   localparam int WB_FRAG = 30;
   localparam int WB_VALID = 31;

   // start-page remainder unit: reciprocal multiply, then multiply back and subtract
   localparam int MOD_STEPS = 2;
   localparam int MSTEP_W = $clog2(MOD_STEPS);

   typedef struct packed {
      logic [1:0]         cmd;
      logic [VPAGE_W-1:0] virt_page;
      logic [CNT_W-1:0]   page_count;
      logic [PPAGE_W-1:0] phys_page;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         entry_flags;
      logic [PPAGE_W-1:0] entry_page;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_MOD,
      S_WALK,
      S_READ,
      S_DRAIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic mod_step;
      logic walk_step;
      logic read_step;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic       clr_last;
      logic [1:0] cmd;
      logic       cnt_zero;
      logic       mod_last;
      logic       walk_last;
      logic       rsp_free;
   } sts_type;

endpackage

### src/tlpt_ctrl.sv
// Controller state machine of the page table mapper.
module tlpt_ctrl import tlpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output ctl_type ctl,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            case (sts.cmd)
               CMD_MAP:   state_in = sts.cnt_zero ? S_DONE : S_MOD;
               CMD_UNMAP: state_in = sts.cnt_zero ? S_DONE : S_WALK;
               CMD_READ:  state_in = S_READ;
               default:   state_in = S_DONE;
            endcase
         end
         S_MOD: begin
            ctl.mod_step = 1'b1;
            if (sts.mod_last) state_in = S_WALK;
         end
         S_WALK: begin
            ctl.walk_step = 1'b1;
            if (sts.walk_last) state_in = (sts.cmd == CMD_MAP) ? S_DONE : S_DRAIN;
         end
         S_READ: begin
            ctl.read_step = 1'b1;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

### src/tlpt_dp.sv
// Datapath of the page table mapper: entry memory, range walker, response register.
module tlpt_dp import tlpt_pkg::*; #(
   parameter int DIR_ENTRIES = 64,
   parameter int TABLE_ENTRIES = 512,
   parameter int FRAG_PAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   output sts_type sts,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int TOTAL = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int AW = $clog2(TOTAL);
   localparam int PHW = $clog2(FRAG_PAGES);
   localparam int VW = VPAGE_W + 1;
   localparam int SW = CNT_W + 2;
   localparam int RSH = VPAGE_W + PHW;
   localparam int PW = RSH + VPAGE_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RSH) + 64'(FRAG_PAGES) - 64'd1) / 64'(FRAG_PAGES);
   localparam logic [VPAGE_W:0] RECIP_M = (VPAGE_W + 1)'(RECIP);
   localparam logic [VPAGE_W-1:0] FRAG_V = VPAGE_W'(FRAG_PAGES);
   localparam logic [VW-1:0] TOTAL_V = VW'(TOTAL);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
   localparam logic [PHW-1:0] PH_LAST = PHW'(FRAG_PAGES - 1);
   localparam logic [SW-1:0] FRAG_S = SW'(FRAG_PAGES);
   localparam logic [MSTEP_W-1:0] MSTEP_LAST = MSTEP_W'(MOD_STEPS - 1);

   logic [MEM_W-1:0] mem [TOTAL];
   logic [MEM_W-1:0] rd_ff;

   logic [1:0]         cmd_ff;
   logic [VW-1:0]      vp_ff;
   logic [PPAGE_W-1:0] pp_ff;
   logic [CNT_W-1:0]   cnt_ff, idx_ff, rem_ff;
   logic [PHW-1:0]     phase_ff;
   logic [VPAGE_W-1:0] quo_ff;
   logic [MSTEP_W-1:0] mstep_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               chk_ff;
   logic               beyond_ff, unm_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               in_range;
   logic [AW-1:0]      addr;
   logic [PW-1:0]      prod;
   logic [VPAGE_W-1:0] quo_f;
   logic [VPAGE_W-1:0] mod_diff;
   logic [PHW-1:0]     mod_phase;
   logic [SW-1:0]      blk;
   logic               frag;
   logic               we, re;
   logic [AW-1:0]      waddr;
   logic [MEM_W-1:0]   wdata;
   logic [1:0]         status;
   rsp_type            rsp_in;

   assign in_range = vp_ff < TOTAL_V;
   assign addr = vp_ff[AW-1:0];

   // start page modulo the fragment size: quotient by reciprocal, then multiply back
   assign prod = PW'(vp_ff[VPAGE_W-1:0]) * PW'(RECIP_M);
   assign quo_f = quo_ff * FRAG_V;
   assign mod_diff = vp_ff[VPAGE_W-1:0] - quo_f;
   assign mod_phase = mod_diff[PHW-1:0];

   // page gets the fragment flag when its whole aligned block lies in the range
   assign blk = SW'(idx_ff) - SW'(phase_ff);
   assign frag = (SW'(idx_ff) >= SW'(phase_ff)) && ((blk + FRAG_S) <= SW'(cnt_ff));

   always_comb begin
      we = ctl.clr_step || (ctl.walk_step && in_range);
      re = (ctl.walk_step && in_range && (cmd_ff == CMD_UNMAP)) ||
           (ctl.read_step && in_range);
      waddr = ctl.clr_step ? clr_addr_ff : addr;
      wdata = '0;
      if (!ctl.clr_step && (cmd_ff == CMD_MAP)) begin
         wdata = {1'b1, frag, 1'b1, 1'b1, pp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_word.cmd;
         vp_ff <= {1'b0, req_word.virt_page};
         pp_ff <= req_word.phys_page;
         cnt_ff <= req_word.page_count;
         rem_ff <= req_word.page_count;
         idx_ff <= '0;
         phase_ff <= '0;
         mstep_ff <= '0;
         beyond_ff <= 1'b0;
         unm_ff <= 1'b0;
      end else begin
         if (ctl.mod_step) begin
            if (mstep_ff == MSTEP_LAST) begin
               phase_ff <= mod_phase;
            end else begin
               quo_ff <= prod[RSH +: VPAGE_W];
            end
            mstep_ff <= mstep_ff + 1'b1;
         end
         if (ctl.walk_step) begin
            vp_ff <= vp_ff + 1'b1;
            pp_ff <= pp_ff + 1'b1;
            idx_ff <= idx_ff + 1'b1;
            rem_ff <= rem_ff - 1'b1;
            phase_ff <= (phase_ff == PH_LAST) ? '0 : phase_ff + 1'b1;
         end
         if ((ctl.walk_step || ctl.read_step) && !in_range) beyond_ff <= 1'b1;
         if (chk_ff && !rd_ff[WB_VALID]) unm_ff <= 1'b1;
      end
      if (ctl.rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         chk_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.clr_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         chk_ff <= re;
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status = beyond_ff ? ST_BEYOND : (unm_ff ? ST_UNMAPPED : ST_OK);
      rsp_in = '0;
      rsp_in.status = status;
      if ((cmd_ff == CMD_READ) && (status == ST_OK)) begin
         rsp_in.entry_flags = {rd_ff[WB_FRAG], rd_ff[WB_WRITE], rd_ff[WB_READ], 1'b1};
         rsp_in.entry_page = rd_ff[PPAGE_W-1:0];
      end
   end

   assign sts.clr_last = clr_addr_ff == LAST_ADDR;
   assign sts.cmd = cmd_ff;
   assign sts.cnt_zero = cnt_ff == '0;
   assign sts.mod_last = mstep_ff == MSTEP_LAST;
   assign sts.walk_last = rem_ff == CNT_W'(1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule

### src/two_level_page_table_mapper_unit.sv
// Two-level page table mapper: one word in, one status word out per command.
// Map: the start-page remainder is found first, then one entry is written per cycle.
// Unmap: entries are read and cleared; read: one entry; zero count or unused cmd: no walk.
// The entry memory's single write port sets the one-page-per-cycle walk.
// After reset, clearing all DIR_ENTRIES * TABLE_ENTRIES entries holds req_ready low.
module two_level_page_table_mapper_unit import tlpt_pkg::*; #(
   parameter int DIR_ENTRIES = 64,
   parameter int TABLE_ENTRIES = 512,
   parameter int FRAG_PAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   ctl_type ctl;
   sts_type sts;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   tlpt_dp #(
      .DIR_ENTRIES   (DIR_ENTRIES),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .FRAG_PAGES    (FRAG_PAGES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while a command is in progress");

   a_fault_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_OK) |->
         (rsp_word.entry_flags == 4'd0) && (rsp_word.entry_page == '0))
      else $error("faulted response carries entry data");

   a_flags_need_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.entry_flags != 4'd0) |-> rsp_word.entry_flags[0])
      else $error("entry flags without valid bit");

endmodule
